/* rtl/core/i2cmbc_pkg.sv */
package i2cmbc_pkg;

  localparam int PHASES_PER_BIT = 5;
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(PHASES_PER_BIT - 1);
  localparam logic [PH_W-1:0] PH_SAMP = PH_W'(PHASES_PER_BIT - 2);
  localparam logic [PH_W-1:0] PH_STOP = PH_W'(PHASES_PER_BIT - 3);

  // bus ops
  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_WTX  = 3'd1;
  localparam logic [2:0] OP_WCMD = 3'd2;
  localparam logic [2:0] OP_RRX  = 3'd3;
  localparam logic [2:0] OP_RST  = 3'd4;

  // config register indexes
  localparam logic [1:0] CFG_PRESCALE = 2'd0;
  localparam logic [1:0] CFG_ENABLE   = 2'd1;
  localparam logic [1:0] CFG_IRQ_EN   = 2'd2;

  // sequencer states
  localparam logic [2:0] SQ_IDLE   = 3'd0;
  localparam logic [2:0] SQ_START  = 3'd1;
  localparam logic [2:0] SQ_WRITE  = 3'd2;
  localparam logic [2:0] SQ_READ   = 3'd3;
  localparam logic [2:0] SQ_ACKIN  = 3'd4;
  localparam logic [2:0] SQ_ACKOUT = 3'd5;
  localparam logic [2:0] SQ_STOP   = 3'd6;

  // pending command bits
  typedef struct packed {
    logic sta;
    logic sto;
    logic rd;
    logic wr;
    logic ack;
  } cmd_t;

  // status bits
  typedef struct packed {
    logic nack;
    logic busy;
    logic al;
    logic tip;
    logic iflag;
  } stat_t;

endpackage

/* rtl/core/i2c_master_byte_controller.sv */
// I2C master byte controller. One request per clock is taken while in_stall is
// low; each is one controller tick, optionally with a register access (op). Its
// result, read data plus the SCL/SDA drive and irq after that tick, comes out of
// a single output register. While that register is stalled, a one-entry skid
// stage takes one more request and in_stall rises the cycle after; with the
// output flowing, throughput is one request per cycle.
// Each bit on the wire takes five phases of prescale+1 ticks; SCL held low by
// a slave stretches the current phase. Status reads return the value before
// the tick of the same request.
module i2c_master_byte_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_wdata,
  input  logic        in_sda_in,
  input  logic        in_scl_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_rdata,
  output logic        out_scl_low,
  output logic        out_sda_low,
  output logic        out_irq
);
  import i2cmbc_pkg::*;

  typedef struct packed {
    logic [7:0] rdata;
    logic       scl_low;
    logic       sda_low;
    logic       irq;
  } res_t;

  // configuration
  logic [15:0] prescale_r;
  logic        enable_r, irq_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= 16'hFFFF;
      enable_r   <= 1'b0;
      irq_en_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESCALE: prescale_r <= cfg_wdata;
        CFG_ENABLE:   enable_r   <= cfg_wdata[0];
        CFG_IRQ_EN:   irq_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // controller state
  logic [15:0]     pcnt_r, pcnt_nxt;
  logic [PH_W-1:0] phase_r, phase_nxt;
  logic [3:0]      bcnt_r, bcnt_nxt;
  logic [7:0]      shift_r, shift_nxt, tx_r, tx_nxt, rx_r, rx_nxt;
  cmd_t            cmd_r, cmd_nxt;
  stat_t           st_r, st_nxt;
  logic [2:0]      sq_r, sq_nxt;
  logic [1:0]      hist_r, hist_nxt;
  logic            own_r, own_nxt;
  res_t            res;

  // output register and skid entry
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r;
  logic take;

  assign in_stall = skid_valid_r;
  assign take     = in_valid && !skid_valid_r;

  // line drive for a given sequencer view
  function automatic logic [1:0] drive_f(input logic [2:0] sq, input logic [PH_W-1:0] ph,
                                         input logic [7:0] sh, input logic ack,
                                         input logic own);
    logic edg;
    edg = (ph == '0) || (ph == PH_LAST);
    case (sq)
      SQ_START:  drive_f = {edg, ph >= PH_W'(2)};
      SQ_STOP:   drive_f = {ph == '0, ph <= PH_STOP};
      SQ_WRITE:  drive_f = {edg, ~sh[7]};
      SQ_READ,
      SQ_ACKIN:  drive_f = {edg, 1'b0};
      SQ_ACKOUT: drive_f = {edg, ~ack};
      default:   drive_f = {own, 1'b0};
    endcase
  endfunction

  always_comb begin
    logic [1:0] drv;
    logic       go, done, ph_end;
    pcnt_nxt  = pcnt_r;
    phase_nxt = phase_r;
    bcnt_nxt  = bcnt_r;
    shift_nxt = shift_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    cmd_nxt   = cmd_r;
    st_nxt    = st_r;
    sq_nxt    = sq_r;
    own_nxt   = own_r;
    go        = 1'b0;
    done      = 1'b0;
    ph_end    = 1'b0;
    drv       = 2'b00;
    res.rdata = 8'h00;

    // register access
    case (in_op)
      OP_RRX: res.rdata = rx_r;
      OP_RST: res.rdata = {st_r.nack, st_r.busy, st_r.al, 3'b000, st_r.tip, st_r.iflag};
      OP_WTX: tx_nxt = in_wdata;
      OP_WCMD: begin
        if (in_wdata[0]) st_nxt.iflag = 1'b0;
        if ((in_wdata[7:4] != 4'h0) && sq_r == SQ_IDLE && enable_r) begin
          cmd_nxt    = cmd_t'(in_wdata[7:3]);
          st_nxt.al  = 1'b0;
          st_nxt.tip = in_wdata[5] | in_wdata[4];
        end
      end
      default: ;
    endcase

    // bus busy detection
    if (in_scl_in && hist_r[1]) begin
      if (hist_r[0] && !in_sda_in) st_nxt.busy = 1'b1;
      else if (!hist_r[0] && in_sda_in) st_nxt.busy = 1'b0;
    end
    hist_nxt = {in_scl_in, in_sda_in};

    if (!enable_r) begin
      sq_nxt = SQ_IDLE; cmd_nxt = '0; phase_nxt = '0; pcnt_nxt = '0;
      bcnt_nxt = '0; own_nxt = 1'b0; st_nxt.tip = 1'b0;
    end else if (sq_r == SQ_IDLE) begin
      go = cmd_nxt.sta | cmd_nxt.sto | cmd_nxt.rd | cmd_nxt.wr;
    end else begin
      drv = drive_f(sq_r, phase_r, shift_r, cmd_r.ack, own_r);
      if (drv[1] || in_scl_in) begin
        if (pcnt_r != prescale_r) begin
          pcnt_nxt = pcnt_r + 16'd1;
        end else begin
          pcnt_nxt = '0;
          ph_end   = 1'b1;
          if (phase_r == PH_SAMP) begin
            if (sq_r == SQ_READ) shift_nxt = {shift_r[6:0], in_sda_in};
            else if (sq_r == SQ_ACKIN) st_nxt.nack = in_sda_in;
            else if (sq_r == SQ_WRITE && shift_r[7] && !in_sda_in) begin
              sq_nxt = SQ_IDLE; cmd_nxt = '0; phase_nxt = '0; own_nxt = 1'b0;
              st_nxt.tip = 1'b0; st_nxt.al = 1'b1; st_nxt.iflag = 1'b1;
              ph_end = 1'b0;
            end
          end
          if (ph_end) begin
            if (phase_r < PH_LAST) begin
              phase_nxt = phase_r + PH_W'(1);
            end else begin
              phase_nxt = '0;
              case (sq_r)
                SQ_START: begin cmd_nxt.sta = 1'b0; own_nxt = 1'b1; done = 1'b1; end
                SQ_WRITE: begin
                  shift_nxt = {shift_r[6:0], 1'b0};
                  bcnt_nxt  = bcnt_r + 4'd1;
                  if (bcnt_r >= 4'd7) begin bcnt_nxt = '0; sq_nxt = SQ_ACKIN; end
                end
                SQ_READ: begin
                  bcnt_nxt = bcnt_r + 4'd1;
                  if (bcnt_r >= 4'd7) begin
                    bcnt_nxt = '0; rx_nxt = shift_nxt; sq_nxt = SQ_ACKOUT;
                  end
                end
                SQ_ACKIN,
                SQ_ACKOUT: begin cmd_nxt.rd = 1'b0; cmd_nxt.wr = 1'b0; done = 1'b1; end
                default: begin cmd_nxt.sto = 1'b0; own_nxt = 1'b0; done = 1'b1; end
              endcase
            end
          end
        end
      end
    end

    // next command of the sequence
    if (go || done) begin
      phase_nxt = '0;
      pcnt_nxt  = '0;
      if (cmd_nxt.sta) sq_nxt = SQ_START;
      else if (cmd_nxt.rd) begin sq_nxt = SQ_READ; shift_nxt = '0; bcnt_nxt = '0; end
      else if (cmd_nxt.wr) begin sq_nxt = SQ_WRITE; shift_nxt = tx_nxt; bcnt_nxt = '0; end
      else if (cmd_nxt.sto) sq_nxt = SQ_STOP;
      else begin
        sq_nxt = SQ_IDLE; cmd_nxt = '0; st_nxt.tip = 1'b0; st_nxt.iflag = 1'b1;
      end
    end

    // drive after this tick
    if (enable_r) begin
      drv = drive_f(sq_nxt, phase_nxt, shift_nxt, cmd_nxt.ack, own_nxt);
    end else begin
      drv = 2'b00;
    end
    res.scl_low = drv[1];
    res.sda_low = drv[0];
    res.irq     = irq_en_r & st_nxt.iflag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= '0; phase_r <= '0; bcnt_r <= '0; shift_r <= '0;
      tx_r <= '0; rx_r <= '0; cmd_r <= '0; st_r <= '0;
      sq_r <= SQ_IDLE; hist_r <= 2'b11; own_r <= 1'b0;
    end else if (take) begin
      pcnt_r <= pcnt_nxt; phase_r <= phase_nxt; bcnt_r <= bcnt_nxt;
      shift_r <= shift_nxt; tx_r <= tx_nxt; rx_r <= rx_nxt; cmd_r <= cmd_nxt;
      st_r <= st_nxt; sq_r <= sq_nxt; hist_r <= hist_nxt; own_r <= own_nxt;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r  <= skid_valid_r | take;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (take && out_valid_r && out_stall) begin
      skid_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_rdata   = out_r.rdata;
  assign out_scl_low = out_r.scl_low;
  assign out_sda_low = out_r.sda_low;
  assign out_irq     = out_r.irq;

endmodule

/* dv/i2c_master_byte_checker.sv */
`timescale 1ns / 100ps

module i2c_master_byte_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_wdata,
  input  logic        in_sda_in,
  input  logic        in_scl_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_rdata,
  input  logic        out_scl_low,
  input  logic        out_sda_low,
  input  logic        out_irq,
  output int          fail_count,
  output int          pending_count,
  output int          checked_count
);
  import i2cmbc_pkg::*;

  typedef struct packed {
    logic [7:0] rdata;
    logic       scl_low;
    logic       sda_low;
    logic       irq;
  } bus_result_t;

  bus_result_t expected_bus_q[$];

  // mirrored registers
  logic [15:0] m_prescale;
  logic        m_enable;
  logic        m_irq_en;

  // mirrored controller state
  logic [15:0] ps_cnt;
  logic [2:0]  ph;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [7:0]  tx_byte;
  logic [7:0]  rx_byte;
  cmd_t        pcmd;
  stat_t       st;
  logic [2:0]  sq;
  logic [1:0]  hist;
  logic        owned;

  assign pending_count = expected_bus_q.size();

  function automatic void line_drive(output logic sl, output logic dl);
    logic at_edge;
    at_edge = (ph == 3'd0) || (ph == PH_LAST);
    sl = 1'b0;
    dl = 1'b0;
    case (sq)
      SQ_START: begin
        sl = at_edge;
        dl = (ph >= 3'd2);
      end
      SQ_STOP: begin
        sl = (ph == 3'd0);
        dl = (ph <= PH_STOP);
      end
      SQ_WRITE: begin
        sl = at_edge;
        dl = !shreg[7];
      end
      SQ_READ, SQ_ACKIN: sl = at_edge;
      SQ_ACKOUT: begin
        sl = at_edge;
        dl = !pcmd.ack;
      end
      default: sl = owned;
    endcase
  endfunction

  function automatic void next_bit_op();
    ph = '0;
    ps_cnt = '0;
    if (pcmd.sta) begin
      sq = SQ_START;
    end else if (pcmd.rd) begin
      sq = SQ_READ;
      shreg = '0;
      bit_cnt = '0;
    end else if (pcmd.wr) begin
      sq = SQ_WRITE;
      shreg = tx_byte;
      bit_cnt = '0;
    end else if (pcmd.sto) begin
      sq = SQ_STOP;
    end else begin
      sq = SQ_IDLE;
      pcmd = '0;
      st.tip = 1'b0;
      st.iflag = 1'b1;
    end
  endfunction

  // one tick of the bit sequencer
  function automatic void sequencer_tick(logic sda, logic scl);
    logic sl, dl;
    if (sq == SQ_IDLE) begin
      if (pcmd.sta || pcmd.sto || pcmd.rd || pcmd.wr) next_bit_op();
      return;
    end
    line_drive(sl, dl);
    if (!sl && !scl) return;  // slave stretching SCL
    if (ps_cnt != m_prescale) begin
      ps_cnt = ps_cnt + 16'd1;
      return;
    end
    ps_cnt = '0;
    if (ph == PH_SAMP) begin
      if (sq == SQ_READ) begin
        shreg = {shreg[6:0], sda};
      end else if (sq == SQ_ACKIN) begin
        st.nack = sda;
      end else if (sq == SQ_WRITE && shreg[7] && !sda) begin
        // lost arbitration
        sq = SQ_IDLE;
        pcmd = '0;
        ph = '0;
        owned = 1'b0;
        st.tip = 1'b0;
        st.al = 1'b1;
        st.iflag = 1'b1;
        return;
      end
    end
    if (ph < PH_LAST) begin
      ph = ph + 3'd1;
      return;
    end
    ph = '0;
    case (sq)
      SQ_START: begin
        pcmd.sta = 1'b0;
        owned = 1'b1;
        next_bit_op();
      end
      SQ_WRITE: begin
        shreg = shreg << 1;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          bit_cnt = '0;
          sq = SQ_ACKIN;
        end
      end
      SQ_READ: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          bit_cnt = '0;
          rx_byte = shreg;
          sq = SQ_ACKOUT;
        end
      end
      SQ_ACKIN, SQ_ACKOUT: begin
        pcmd.rd = 1'b0;
        pcmd.wr = 1'b0;
        next_bit_op();
      end
      default: begin
        pcmd.sto = 1'b0;
        owned = 1'b0;
        next_bit_op();
      end
    endcase
  endfunction

  function automatic bus_result_t predict_bus(logic [2:0] op, logic [7:0] wd,
                                              logic sda, logic scl);
    bus_result_t r;
    logic sl, dl;
    r = '0;
    case (op)
      OP_RRX: r.rdata = rx_byte;
      OP_RST: r.rdata = {st.nack, st.busy, st.al, 3'b000, st.tip, st.iflag};
      OP_WTX: tx_byte = wd;
      OP_WCMD: begin
        if (wd[0]) st.iflag = 1'b0;
        if (|wd[7:4] && sq == SQ_IDLE && m_enable) begin
          pcmd = cmd_t'(wd[7:3]);
          st.al = 1'b0;
          st.tip = |wd[5:4];
        end
      end
      default: ;
    endcase
    // start/stop detection on the sampled lines
    if (scl && hist[1]) begin
      if (hist[0] && !sda) st.busy = 1'b1;
      else if (!hist[0] && sda) st.busy = 1'b0;
    end
    hist = {scl, sda};
    if (!m_enable) begin
      sq = SQ_IDLE;
      pcmd = '0;
      ph = '0;
      ps_cnt = '0;
      bit_cnt = '0;
      owned = 1'b0;
      st.tip = 1'b0;
      sl = 1'b0;
      dl = 1'b0;
    end else begin
      sequencer_tick(sda, scl);
      line_drive(sl, dl);
    end
    r.scl_low = sl;
    r.sda_low = dl;
    r.irq = m_irq_en && st.iflag;
    return r;
  endfunction

  always @(posedge clk) begin
    bus_result_t exp_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      m_prescale <= 16'hFFFF;
      m_enable <= 1'b0;
      m_irq_en <= 1'b0;
      ps_cnt = '0;
      ph = '0;
      bit_cnt = '0;
      shreg = '0;
      tx_byte = '0;
      rx_byte = '0;
      pcmd = '0;
      st = '0;
      sq = SQ_IDLE;
      hist = 2'b11;
      owned = 1'b0;
      expected_bus_q.delete();
      fail_count <= 0;
      checked_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRESCALE: m_prescale <= cfg_wdata;
          CFG_ENABLE:   m_enable <= cfg_wdata[0];
          CFG_IRQ_EN:   m_irq_en <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_bus_q.push_back(predict_bus(in_op, in_wdata, in_sda_in, in_scl_in));
      if (out_valid && !out_stall) begin
        checked_count <= checked_count + 1;
        if (expected_bus_q.size() == 0) begin
          $error("unexpected result: rdata %0h", out_rdata);
          errs++;
        end else begin
          exp_r = expected_bus_q.pop_front();
          if (exp_r.rdata !== out_rdata) begin
            $error("rdata: expected %0h, got %0h", exp_r.rdata, out_rdata);
            errs++;
          end
          if (exp_r.scl_low !== out_scl_low) begin
            $error("scl_low: expected %0b, got %0b", exp_r.scl_low, out_scl_low);
            errs++;
          end
          if (exp_r.sda_low !== out_sda_low) begin
            $error("sda_low: expected %0b, got %0b", exp_r.sda_low, out_sda_low);
            errs++;
          end
          if (exp_r.irq !== out_irq) begin
            $error("irq: expected %0b, got %0b", exp_r.irq, out_irq);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

/* dv/tb_i2c_master_byte_controller.sv */
`timescale 1ns / 100ps

module tb_i2c_master_byte_controller;
  import i2cmbc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_PRESCALE;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = OP_TICK;
  logic [7:0]  in_wdata = '0;
  logic        in_sda_in = 1'b1;
  logic        in_scl_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_rdata;
  logic        out_scl_low;
  logic        out_sda_low;
  logic        out_irq;

  int fail_count;
  int pending_count;
  int checked_count;
  int req_sent = 0;
  int cycle_cnt;
  logic [15:0] cur_prescale = 16'hFFFF;

  i2c_master_byte_controller u_top (.*);

  i2c_master_byte_checker u_chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall, one long hold-off to back up the block, and a stall-free stretch
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (cycle_cnt == 200) begin
        hold = 120;
        out_stall <= 1'b1;
      end else if (cycle_cnt > 350 && cycle_cnt < 550) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 11);
      end
    end
  end

  initial begin
    #(20ms);
    $display("i2c_master_byte_controller regression: fail");
    $finish;
  end

  // one request, held until taken
  task automatic send_req(logic [2:0] op, logic [7:0] wd, logic sda, logic scl);
    logic quiet;
    quiet = (req_sent > 250 && req_sent < 350);
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_wdata <= wd;
    in_sda_in <= sda;
    in_scl_in <= scl;
    do @(posedge clk); while (in_stall);
    req_sent++;
  endtask

  // write enable stays up across back-to-back writes; caller drops it
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // drain outstanding requests before touching registers
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(logic [15:0] ps, logic en, logic irq_en);
    drain_block();
    write_reg(CFG_PRESCALE, ps);
    write_reg(CFG_ENABLE, {15'd0, en});
    write_reg(CFG_IRQ_EN, {15'd0, irq_en});
    cfg_we <= 1'b0;
    cur_prescale = ps;
  endtask

  // bus tick with lines mostly idle-high; occasional stretch or low SDA, status or rx read, or unused op
  task automatic bus_tick();
    logic [2:0] op;
    op = OP_TICK;
    case ($urandom_range(19))
      0: op = OP_RST;
      1: op = OP_RRX;
      2: op = 3'($urandom_range(7, 5));
      default: ;
    endcase
    send_req(op, 8'($urandom), $urandom_range(99) >= 12, $urandom_range(99) >= 5);
  endtask

  // a well-formed transfer: load data, issue a command, let it run
  task automatic byte_transfer();
    logic [7:0] cmds[10];
    int ticks;
    cmds = '{8'h90, 8'h10, 8'h20, 8'h28, 8'h40, 8'h50, 8'hA0, 8'h68, 8'hB1, 8'h30};
    send_req(OP_WTX, 8'($urandom), 1'b1, 1'b1);
    if ($urandom_range(9) == 0) send_req(OP_WCMD, 8'h01, 1'b1, 1'b1);
    send_req(OP_WCMD, cmds[$urandom_range(9)], 1'b1, 1'b1);
    ticks = (cur_prescale > 16'd8) ? 25 : 55 * (cur_prescale + 1) + $urandom_range(10);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(49) == 0) send_req(OP_WCMD, 8'($urandom), 1'b1, 1'b1);
      else bus_tick();
    end
    send_req(OP_RST, 8'h00, 1'b1, 1'b1);
    send_req(OP_WCMD, 8'h01, 1'b1, 1'b1);
  endtask

  initial begin
    logic [15:0] ps_list[6];
    logic        en_list[6];
    logic        irq_list[6];
    int          quota;
    ps_list = '{16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd2, 16'd0};
    en_list = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    irq_list = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: every op, field extremes, bus start and stop seen
    for (int op = 0; op < 8; op++)
      send_req(3'(op), (op % 2) ? 8'hFF : 8'h00, 1'b1, 1'b1);
    send_req(OP_TICK, 8'h00, 1'b0, 1'b1);
    send_req(OP_RST, 8'h00, 1'b1, 1'b1);
    send_req(OP_WCMD, 8'hF9, 1'b0, 1'b0);

    // enabled, fastest clock: ack-only (no command bits), start+write, then read+write and stop sent while busy
    set_mode(16'd0, 1'b1, 1'b1);
    send_req(OP_WTX, 8'hFF, 1'b1, 1'b1);
    send_req(OP_WCMD, 8'h08, 1'b1, 1'b1);
    send_req(OP_WCMD, 8'h90, 1'b1, 1'b1);
    send_req(OP_WCMD, 8'h40, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) send_req(OP_TICK, 8'h00, 1'b1, i != 2);
    send_req(OP_TICK, 8'h00, 1'b0, 1'b1);
    send_req(OP_RST, 8'h00, 1'b1, 1'b1);
    send_req(OP_WCMD, 8'h01, 1'b1, 1'b1);
    send_req(OP_WCMD, 8'h30, 1'b1, 1'b1);
    send_req(OP_WCMD, 8'h40, 1'b1, 1'b1);

    for (int m = 0; m < 6; m++) begin
      set_mode(ps_list[m], en_list[m], irq_list[m]);
      quota = req_sent + ((ps_list[m] > 16'd8) ? 30 : 60);
      while (req_sent < quota) byte_transfer();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 10000 && pending_count != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d requests, %0d results checked over 7 register settings",
             req_sent, checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("i2c_master_byte_controller regression: pass");
    end else begin
      $display("i2c_master_byte_controller regression: fail");
    end
    $finish;
  end

endmodule
